### src/wheel_speed_pid_motor_drive_core_assert.svh
// Assertion macros for the wheel speed PID core and its port checker.
// No dependencies; included by the checker file.
`ifndef WHEEL_SPEED_PID_MOTOR_DRIVE_CORE_ASSERT_SVH
`define WHEEL_SPEED_PID_MOTOR_DRIVE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled while dis is high
`define WSPID_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSPID_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/wspid_pkg.sv
// Shared types and constants of the wheel speed PID core: payloads, config,
// microcode control word. No dependencies.
package wspid_pkg;

   // payloads
   typedef struct packed {
      logic signed [15:0] pulse_count;
      logic               clear;
   } req_payload_type;

   typedef struct packed {
      logic [14:0]        duty_us;
      logic signed [23:0] measured_speed;
      logic signed [31:0] pid_term;
      logic               clamped;
   } rsp_payload_type;

   // configuration registers
   typedef struct packed {
      logic [31:0] kp_gain;
      logic [31:0] ki_gain;
      logic [31:0] kd_gain;
      logic [15:0] target_speed;
      logic [15:0] speed_scale;
      logic [14:0] duty_bias;
      logic [14:0] duty_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      kp_gain:      32'd671089,
      ki_gain:      32'd16777,
      kd_gain:      32'd168,
      target_speed: 16'd400,
      speed_scale:  16'd26453,
      duty_bias:    15'd1290,
      duty_limit:   15'd20000
   };

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP_GAIN      = 3'd0,
      CSR_KI_GAIN      = 3'd1,
      CSR_KD_GAIN      = 3'd2,
      CSR_TARGET_SPEED = 3'd3,
      CSR_SPEED_SCALE  = 3'd4,
      CSR_DUTY_BIAS    = 3'd5,
      CSR_DUTY_LIMIT   = 3'd6
   } csr_index_type;

   // datapath widths
   localparam int MUL_A_W = 33;   // unsigned 32-bit gain, sign bit added
   localparam int MUL_B_W = 26;   // signed operand
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 74;   // ki * 40-bit sum plus two smaller terms

   // microcode
   localparam int UCODE_LEN = 9;
   localparam int STEP_W    = $clog2(UCODE_LEN);

   typedef enum logic [1:0] {MA_SCALE, MA_KP, MA_KI, MA_KD} mul_a_sel_type;
   typedef enum logic [2:0] {MB_DIFF, MB_ERROR, MB_SUM_LO, MB_SUM_HI, MB_DERIV}
      mul_b_sel_type;
   typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_ADD_HI} acc_op_type;
   typedef enum logic [2:0] {OP_NONE, OP_SPEED, OP_INTEG, OP_PID, OP_DUTY}
      unit_op_type;
   // SQ_FINISH: leave the program once the output register can take the result
   typedef enum logic {SQ_NEXT, SQ_FINISH} flow_type;

   typedef struct packed {
      mul_a_sel_type mul_a;
      mul_b_sel_type mul_b;
      acc_op_type    acc_op;
      unit_op_type   unit_op;
      flow_type      flow;
   } ucode_word_type;

   localparam ucode_word_type UCODE_IDLE = '{
      mul_a: MA_SCALE, mul_b: MB_DIFF, acc_op: ACC_NONE, unit_op: OP_NONE, flow: SQ_NEXT
   };

endpackage

### src/wspid_seq.sv
// Microcode sequencer: step counter over a read-only program of control words.
// Depends on wspid_pkg.
module wspid_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      out_free,
   output wspid_pkg::ucode_word_type ctrl,
   output logic                      busy
);

   localparam wspid_pkg::ucode_word_type UCODE [wspid_pkg::UCODE_LEN] = '{
      // 0: diff * speed_scale
      '{wspid_pkg::MA_SCALE, wspid_pkg::MB_DIFF,   wspid_pkg::ACC_NONE,
        wspid_pkg::OP_NONE,  wspid_pkg::SQ_NEXT},
      // 1: speed, error
      '{wspid_pkg::MA_SCALE, wspid_pkg::MB_DIFF,   wspid_pkg::ACC_NONE,
        wspid_pkg::OP_SPEED, wspid_pkg::SQ_NEXT},
      // 2: integrate, derivative; kp * error
      '{wspid_pkg::MA_KP,    wspid_pkg::MB_ERROR,  wspid_pkg::ACC_NONE,
        wspid_pkg::OP_INTEG, wspid_pkg::SQ_NEXT},
      // 3: ki * sum low half; acc = kp term
      '{wspid_pkg::MA_KI,    wspid_pkg::MB_SUM_LO, wspid_pkg::ACC_LOAD,
        wspid_pkg::OP_NONE,  wspid_pkg::SQ_NEXT},
      // 4: ki * sum high half; add low partial
      '{wspid_pkg::MA_KI,    wspid_pkg::MB_SUM_HI, wspid_pkg::ACC_ADD,
        wspid_pkg::OP_NONE,  wspid_pkg::SQ_NEXT},
      // 5: kd * deriv; add high partial shifted
      '{wspid_pkg::MA_KD,    wspid_pkg::MB_DERIV,  wspid_pkg::ACC_ADD_HI,
        wspid_pkg::OP_NONE,  wspid_pkg::SQ_NEXT},
      // 6: add kd term
      '{wspid_pkg::MA_KD,    wspid_pkg::MB_DERIV,  wspid_pkg::ACC_ADD,
        wspid_pkg::OP_NONE,  wspid_pkg::SQ_NEXT},
      // 7: round and saturate pid term
      '{wspid_pkg::MA_KD,    wspid_pkg::MB_DERIV,  wspid_pkg::ACC_NONE,
        wspid_pkg::OP_PID,   wspid_pkg::SQ_NEXT},
      // 8: duty clamp, hand result over
      '{wspid_pkg::MA_KD,    wspid_pkg::MB_DERIV,  wspid_pkg::ACC_NONE,
        wspid_pkg::OP_DUTY,  wspid_pkg::SQ_FINISH}
   };

   logic [wspid_pkg::STEP_W-1:0] step_ff, step_in;
   logic                         busy_ff, busy_in;
   wspid_pkg::ucode_word_type    word;

   assign word = UCODE[step_ff];

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         unique case (word.flow)
            wspid_pkg::SQ_NEXT:   step_in = step_ff + wspid_pkg::STEP_W'(1);
            wspid_pkg::SQ_FINISH: if (out_free) busy_in = 1'b0;
            default:              step_in = step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctrl = busy_ff ? word : wspid_pkg::UCODE_IDLE;
   assign busy = busy_ff;

endmodule

### src/wspid_datapath.sv
// PID datapath: one shared 33x26 multiplier, accumulator, loop state.
// Depends on wspid_pkg; driven by wspid_seq control words.
module wspid_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  wspid_pkg::req_payload_type req,
   input  wspid_pkg::cfg_type         cfg,
   input  wspid_pkg::ucode_word_type  ctrl,
   output wspid_pkg::rsp_payload_type result
);

   localparam int PW = wspid_pkg::PROD_W;
   localparam int AW = wspid_pkg::ACC_W;

   // loop state
   logic [15:0] last_count_ff, last_count_in;
   logic [39:0] sum_ff, sum_in;
   logic [24:0] last_error_ff, last_error_in;
   // work registers
   logic [15:0] diff_ff, diff_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [23:0] speed_ff, speed_in;
   logic [24:0] error_ff, error_in;
   logic [25:0] deriv_ff, deriv_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [31:0] pid_ff, pid_in;

   logic signed [wspid_pkg::MUL_A_W-1:0] a_v;
   logic signed [wspid_pkg::MUL_B_W-1:0] b_v;
   logic [33:0] spd_t;
   logic [25:0] spd_r;
   logic [40:0] sum_w;
   logic [AW-1:0] prod_ext;
   logic [AW-1:0] pid_t;
   logic [49:0] pid_r;
   logic [33:0] dsum;

   // multiplier operand select
   always_comb begin
      case (ctrl.mul_a)
         wspid_pkg::MA_SCALE: a_v = {17'b0, cfg.speed_scale};
         wspid_pkg::MA_KP:    a_v = {1'b0, cfg.kp_gain};
         wspid_pkg::MA_KI:    a_v = {1'b0, cfg.ki_gain};
         default:             a_v = {1'b0, cfg.kd_gain};
      endcase
      case (ctrl.mul_b)
         wspid_pkg::MB_DIFF:   b_v = {{10{diff_ff[15]}}, diff_ff};
         wspid_pkg::MB_ERROR:  b_v = {error_ff[24], error_ff};
         wspid_pkg::MB_SUM_LO: b_v = {6'b0, sum_ff[19:0]};
         wspid_pkg::MB_SUM_HI: b_v = {{6{sum_ff[39]}}, sum_ff[39:20]};
         default:              b_v = deriv_ff;
      endcase
   end

   assign prod_in = PW'(a_v) * PW'(b_v);

   // speed: round half up by 2^8, saturate to 24 bits
   assign spd_t = {prod_ff[32], prod_ff[32:0]} + 34'd128;
   assign spd_r = spd_t[33:8];

   assign sum_w = {sum_ff[39], sum_ff} + {{16{error_ff[24]}}, error_ff};
   assign prod_ext = {{(AW-PW){prod_ff[PW-1]}}, prod_ff};

   // pid: round half up by 2^24, saturate to 32 bits
   assign pid_t = acc_ff + AW'(24'h800000);
   assign pid_r = pid_t[AW-1:24];

   always_comb begin
      last_count_in = last_count_ff;
      sum_in        = sum_ff;
      last_error_in = last_error_ff;
      diff_in       = diff_ff;
      speed_in      = speed_ff;
      error_in      = error_ff;
      deriv_in      = deriv_ff;
      acc_in        = acc_ff;
      pid_in        = pid_ff;

      if (start) begin
         // clear restarts the loop: difference taken against zero
         diff_in       = req.pulse_count - (req.clear ? 16'd0 : last_count_ff);
         last_count_in = req.pulse_count;
         if (req.clear) begin
            sum_in        = '0;
            last_error_in = '0;
         end
      end

      case (ctrl.unit_op)
         wspid_pkg::OP_SPEED: begin
            if (spd_r[25:23] == 3'b000 || spd_r[25:23] == 3'b111)
               speed_in = spd_r[23:0];
            else
               speed_in = spd_r[25] ? 24'h800000 : 24'h7FFFFF;
            error_in = {9'b0, cfg.target_speed} - {speed_in[23], speed_in};
         end
         wspid_pkg::OP_INTEG: begin
            if (sum_w[40] != sum_w[39])
               sum_in = sum_w[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
            else
               sum_in = sum_w[39:0];
            deriv_in      = {error_ff[24], error_ff} - {last_error_ff[24], last_error_ff};
            last_error_in = error_ff;
         end
         wspid_pkg::OP_PID: begin
            if (pid_r[49:31] == {19{pid_r[49]}})
               pid_in = pid_r[31:0];
            else
               pid_in = pid_r[49] ? 32'h80000000 : 32'h7FFFFFFF;
         end
         default: ;
      endcase

      case (ctrl.acc_op)
         wspid_pkg::ACC_LOAD:   acc_in = prod_ext;
         wspid_pkg::ACC_ADD:    acc_in = acc_ff + prod_ext;
         wspid_pkg::ACC_ADD_HI: acc_in = acc_ff + {prod_ext[AW-21:0], 20'b0};
         default:               acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
         sum_ff        <= '0;
         last_error_ff <= '0;
      end else begin
         last_count_ff <= last_count_in;
         sum_ff        <= sum_in;
         last_error_ff <= last_error_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      speed_ff <= speed_in;
      error_ff <= error_in;
      deriv_ff <= deriv_in;
      acc_ff   <= acc_in;
      pid_ff   <= pid_in;
   end

   // duty: bias + pid, clamped to 0..duty_limit
   assign dsum = {{2{pid_ff[31]}}, pid_ff} + {19'b0, cfg.duty_bias};

   always_comb begin
      if (dsum[33]) begin
         result.duty_us = '0;
         result.clamped = 1'b1;
      end else if (dsum > {19'b0, cfg.duty_limit}) begin
         result.duty_us = cfg.duty_limit;
         result.clamped = 1'b1;
      end else begin
         result.duty_us = dsum[14:0];
         result.clamped = 1'b0;
      end
      result.measured_speed = speed_ff;
      result.pid_term       = pid_ff;
   end

endmodule

### src/wheel_speed_pid_motor_drive_core.sv
// Wheel speed PID core, top level. Depends on wspid_pkg, wspid_seq and
// wspid_datapath.
//
// One req transfer per sample tick carries the raw wheel pulse counter and a
// clear flag; each one produces exactly one rsp transfer with the motor duty
// in us, the measured speed, the PID term before bias and a clamp flag.
// Gains, target, speed scale, bias and duty limit live in seven registers on
// the csr write channel (index 0..6, index 7 ignored); csr_ready is always
// high. Write them only while no sample is in flight.
// A nine-step microprogram runs every product through a single 33x26
// multiplier; req_ready is low while it runs, so a new sample is taken only
// once the previous one has finished its program.
// The finished result sits in an output register, so req_ready returns as
// soon as it is loaded and the next sample can start while rsp waits.
// If rsp_ready is low and the output register is still full, the last step
// holds until it drains; nothing is dropped.
// Reset (synchronous, active high) loads the register defaults and clears
// the integral, last error and last count.
module wheel_speed_pid_motor_drive_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample in
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  wspid_pkg::req_payload_type            req_data,
   // result out
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output wspid_pkg::rsp_payload_type            rsp_data,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wspid_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wspid_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   wspid_pkg::cfg_type         cfg_ff, cfg_in;
   wspid_pkg::ucode_word_type  ctrl;
   wspid_pkg::rsp_payload_type result;
   wspid_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       busy;
   logic                       start;
   logic                       out_free;
   logic                       load_out;

   assign csr_ready = 1'b1;
   assign req_ready = !busy;
   assign start     = req_valid && req_ready;
   // output register empty, or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_out  = (ctrl.unit_op == wspid_pkg::OP_DUTY) && out_free;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (wspid_pkg::csr_index_type'(csr_index))
            wspid_pkg::CSR_KP_GAIN:      cfg_in.kp_gain      = csr_wdata;
            wspid_pkg::CSR_KI_GAIN:      cfg_in.ki_gain      = csr_wdata;
            wspid_pkg::CSR_KD_GAIN:      cfg_in.kd_gain      = csr_wdata;
            wspid_pkg::CSR_TARGET_SPEED: cfg_in.target_speed = csr_wdata[15:0];
            wspid_pkg::CSR_SPEED_SCALE:  cfg_in.speed_scale  = csr_wdata[15:0];
            wspid_pkg::CSR_DUTY_BIAS:    cfg_in.duty_bias    = csr_wdata[14:0];
            wspid_pkg::CSR_DUTY_LIMIT:   cfg_in.duty_limit   = csr_wdata[14:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= wspid_pkg::CFG_RESET;
      else       cfg_ff <= cfg_in;
   end

   wspid_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   wspid_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_data),
      .cfg    (cfg_ff),
      .ctrl   (ctrl),
      .result (result)
   );

   // output register: loaded on the last step, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/wspid_port_checker.sv
// Port-level checks of the wheel speed PID core, bound to the top level.
// Depends on wspid_pkg and the assertion macro header.
`include "wheel_speed_pid_motor_drive_core_assert.svh"

module wspid_port_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input wspid_pkg::rsp_payload_type rsp_data
);

   // reset leaves nothing pending and the input open
   `WSPID_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "not idle after reset")

   // a sample transfer starts the program, input closes
   `WSPID_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "req_ready high during a step")

   // a new result only appears at the end of a running program
   `WSPID_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(!req_ready), "result without work")

   // stalled result holds
   `WSPID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind wheel_speed_pid_motor_drive_core wspid_port_checker u_port_checker (.*);

### dv/wspid_speed_loop_checker.sv
// Result checker for the wheel speed PID core: watches the sample, result and
// register channels, predicts each motor drive result and compares it.
// Depends on wspid_pkg only.
module wspid_speed_loop_checker
   import wspid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_payload_type        req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_payload_type        rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     results_pending,
   output int                     results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MISMATCH_REPORTS = 10;
   localparam logic [95:0]        PRODUCT_CAP = 96'd1 << 60;
   localparam logic signed [95:0] SPEED_HI    = 96'sd8388607;
   localparam logic signed [95:0] SPEED_LO    = -96'sd8388608;
   localparam logic signed [95:0] INTEG_HI    = 96'sd549755813887;
   localparam logic signed [95:0] INTEG_LO    = -96'sd549755813888;
   localparam logic signed [95:0] TERM_HI     = 96'sd2147483647;
   localparam logic signed [95:0] TERM_LO     = -96'sd2147483648;

   // own copy of the registers and the loop state
   cfg_type              settings;
   logic [15:0]          prev_count;
   logic signed [39:0]   integ;
   logic signed [24:0]   prev_error;

   rsp_payload_type      drive_q[$];
   rsp_payload_type      want;
   int                   bad_total;
   int                   checked_total;

   function automatic logic signed [95:0] clip(logic signed [95:0] x,
                                               logic signed [95:0] lo,
                                               logic signed [95:0] hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // round to nearest, ties toward +inf
   function automatic logic signed [95:0] round_shift(logic signed [95:0] x, int s);
      return (x + (96'sd1 <<< (s - 1))) >>> s;
   endfunction

   // unsigned gain times signed operand, magnitude capped at 2^60
   function automatic logic signed [95:0] gain_product(logic [31:0] gain,
                                                       logic signed [95:0] v);
      logic [95:0] mag;
      logic [95:0] prod;
      mag  = v[95] ? $unsigned(-v) : $unsigned(v);
      prod = mag * {64'd0, gain};
      if (prod > PRODUCT_CAP)
         prod = PRODUCT_CAP;
      return v[95] ? -$signed(prod) : $signed(prod);
   endfunction

   // one sample tick: speed, PID step, duty clamp; updates the loop state
   function automatic rsp_payload_type compute_drive(req_payload_type s);
      logic [15:0]        delta;
      logic signed [95:0] diff, speed, err, deriv, acc, pid, duty;
      rsp_payload_type    r;
      if (s.clear) begin
         integ      = '0;
         prev_error = '0;
         prev_count = '0;
      end
      delta = s.pulse_count - prev_count;
      diff  = $signed(delta);
      speed = clip(round_shift(diff * $signed({1'b0, settings.speed_scale}), 8),
                   SPEED_LO, SPEED_HI);
      err   = $signed({1'b0, settings.target_speed}) - speed;
      integ = clip(integ + err, INTEG_LO, INTEG_HI);
      deriv = err - prev_error;
      acc   = gain_product(settings.kp_gain, err) + gain_product(settings.ki_gain, integ)
            + gain_product(settings.kd_gain, deriv);
      pid   = clip(round_shift(acc, 24), TERM_LO, TERM_HI);
      duty  = $signed({1'b0, settings.duty_bias}) + pid;
      r.clamped = 1'b0;
      if (duty < 0) begin
         duty      = '0;
         r.clamped = 1'b1;
      end else if (duty > $signed({1'b0, settings.duty_limit})) begin
         duty      = $signed({1'b0, settings.duty_limit});
         r.clamped = 1'b1;
      end
      prev_error       = err[24:0];
      prev_count       = s.pulse_count;
      r.duty_us        = duty[14:0];
      r.measured_speed = speed[23:0];
      r.pid_term       = pid[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         settings   = CFG_RESET;
         prev_count = '0;
         integ      = '0;
         prev_error = '0;
         drive_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (drive_q.size() == 0) begin
               bad_total++;
               if (bad_total <= MISMATCH_REPORTS)
                  $display("%0t: result with nothing expected: duty %0d speed %0d term %0d clamp %0b",
                           $realtime, rsp_data.duty_us, rsp_data.measured_speed,
                           rsp_data.pid_term, rsp_data.clamped);
            end else begin
               want = drive_q.pop_front();
               checked_total++;
               if (rsp_data.duty_us !== want.duty_us
                   || rsp_data.measured_speed !== want.measured_speed
                   || rsp_data.pid_term !== want.pid_term
                   || rsp_data.clamped !== want.clamped) begin
                  bad_total++;
                  if (bad_total <= MISMATCH_REPORTS) begin
                     $display("%0t: result %0d mismatch (expected / actual)",
                              $realtime, checked_total);
                     $display("   duty %0d / %0d  speed %0d / %0d  term %0d / %0d  clamp %0b / %0b",
                              want.duty_us, rsp_data.duty_us,
                              want.measured_speed, rsp_data.measured_speed,
                              want.pid_term, rsp_data.pid_term,
                              want.clamped, rsp_data.clamped);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_KP_GAIN:      settings.kp_gain      = csr_wdata;
               CSR_KI_GAIN:      settings.ki_gain      = csr_wdata;
               CSR_KD_GAIN:      settings.kd_gain      = csr_wdata;
               CSR_TARGET_SPEED: settings.target_speed = csr_wdata[15:0];
               CSR_SPEED_SCALE:  settings.speed_scale  = csr_wdata[15:0];
               CSR_DUTY_BIAS:    settings.duty_bias    = csr_wdata[14:0];
               CSR_DUTY_LIMIT:   settings.duty_limit   = csr_wdata[14:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            drive_q.push_back(compute_drive(req_data));
      end
      mismatch_count  <= bad_total;
      results_pending <= drive_q.size();
      results_checked <= checked_total;
   end

endmodule

### dv/testbench.sv
// Top of the wheel speed PID core testbench: clock, reset, stimulus on the
// sample and register channels, result back-pressure and the verdict.
// Depends on wspid_pkg, wheel_speed_pid_motor_drive_core, wspid_speed_loop_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wspid_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 3;
   localparam int PHASES        = 8;
   localparam int PHASE_SAMPLES = 210;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   // settings flavors used per phase
   typedef enum int {SET_TYPICAL, SET_ALL_ONES, SET_ALL_ZERO, SET_RANDOM, SET_BIAS_OVER}
      setting_kind_type;
   localparam setting_kind_type PHASE_KIND[PHASES] = '{
      SET_TYPICAL, SET_ALL_ONES, SET_TYPICAL, SET_ALL_ZERO,
      SET_RANDOM, SET_BIAS_OVER, SET_TYPICAL, SET_RANDOM
   };

   // directed samples at reset settings: clear from zero, counter wrap both
   // ways, full scale speed both signs (duty driven to zero and to the limit),
   // standing still to wind up the integral, clear in the middle of a run
   localparam int DIRECTED_N = 22;
   localparam int DIRECTED_COUNT[DIRECTED_N] = '{
      0, 0, 5, 10, 32767, -32768, -32768, 0, -32768, 32767, -1,
      0, 1, 100, 100, -100, 32000, -32000, 0, 4, 8, 12
   };
   localparam bit DIRECTED_CLEAR[DIRECTED_N] = '{
      1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0
   };

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_count;
   int results_pending;
   int results_checked;

   int          cycle_count    = 0;
   int          send_idle_pct  = 0;     // chance per cycle the sender holds off
   int          recv_stall_pct = 0;     // chance per cycle rsp_ready is low
   int          samples_sent   = 0;
   int          clears_sent    = 0;
   int          csr_writes     = 0;
   logic [15:0] stream_count   = '0;    // last counter value sent

   always #CLOCK_HALF clock = ~clock;

   wheel_speed_pid_motor_drive_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wspid_speed_loop_checker speed_loop_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   // result side back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, results_pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   // One sample transfer. Valid is only dropped when the sender takes a gap,
   // so back-to-back samples keep it high with a single assignment per edge.
   task automatic send_sample(input logic [15:0] count, input logic clr);
      req_payload_type s;
      s.pulse_count = count;
      s.clear       = clr;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      stream_count = count;
      samples_sent++;
      if (clr)
         clears_sent++;
   endtask

   // Stop sending and wait until every owed result has been taken. The first
   // edge lets the checker count the sample accepted on this edge.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0)
         @(posedge clock);
   endtask

   // one register write; valid stays high for the next write of a batch
   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
   endtask

   function automatic cfg_type pick_settings(setting_kind_type kind);
      cfg_type c;
      case (kind)
         SET_ALL_ONES: begin
            c = '1;
         end
         SET_ALL_ZERO: begin
            c = '0;
         end
         SET_RANDOM: begin
            c.kp_gain      = $urandom();
            c.ki_gain      = $urandom();
            c.kd_gain      = $urandom();
            c.target_speed = 16'($urandom_range(65535));
            c.speed_scale  = 16'($urandom_range(65535));
            c.duty_bias    = 15'($urandom_range(32767));
            c.duty_limit   = 15'($urandom_range(32767));
         end
         default: begin
            // plausible loop: gains up to a few us per mm/s
            c.kp_gain      = $urandom_range(1 << 26);
            c.ki_gain      = $urandom_range(1 << 22);
            c.kd_gain      = $urandom_range(1 << 22);
            c.target_speed = 16'($urandom_range(3000));
            c.speed_scale  = 16'($urandom_range(65535));
            c.duty_bias    = 15'($urandom_range(20000));
            c.duty_limit   = 15'($urandom_range(1000, 20000));
            if (kind == SET_BIAS_OVER) begin
               c.duty_bias  = 15'd20000;
               c.duty_limit = 15'($urandom_range(5000));
            end
         end
      endcase
      return c;
   endfunction

   // all seven registers, then a write to the unmapped index that must be dropped
   task automatic load_settings(input cfg_type c);
      csr_put(CSR_KP_GAIN, c.kp_gain);
      csr_put(CSR_KI_GAIN, c.ki_gain);
      csr_put(CSR_KD_GAIN, c.kd_gain);
      csr_put(CSR_TARGET_SPEED, {16'd0, c.target_speed});
      csr_put(CSR_SPEED_SCALE, {16'd0, c.speed_scale});
      csr_put(CSR_DUTY_BIAS, {17'd0, c.duty_bias});
      csr_put(CSR_DUTY_LIMIT, {17'd0, c.duty_limit});
      csr_put(CSR_UNMAPPED, $urandom());
      csr_valid <= 1'b0;
   endtask

   // Mostly a running counter moving by small steps with the odd large one,
   // plus a few clears and raw jumps to anywhere in the 16-bit range.
   task automatic send_random_sample();
      int          pick;
      int          span;
      logic [15:0] step;
      pick = $urandom_range(99);
      span = ($urandom_range(9) == 0) ? 32767 : 40;
      step = 16'($urandom_range(2 * span)) - 16'(span);
      if (pick < 4)
         send_sample(16'($urandom()), 1'b1);
      else if (pick < 10)
         send_sample(16'($urandom()), 1'b0);
      else
         send_sample(stream_count + step, 1'b0);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed samples against the reset register values, no idling
      for (int i = 0; i < DIRECTED_N; i++)
         send_sample(16'(DIRECTED_COUNT[i]), DIRECTED_CLEAR[i]);

      // Each phase: sender waits for all results, the registers are rewritten
      // while idle, then random samples under one of four idling patterns.
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         repeat (4) @(posedge clock);
         load_settings(pick_settings(PHASE_KIND[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         for (int n = 0; n < PHASE_SAMPLES; n++)
            send_random_sample();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d samples (%0d with clear) over %0d register settings, %0d csr writes",
               samples_sent, clears_sent, PHASES + 1, csr_writes);
      $display("results checked %0d, mismatches %0d, results owed %0d",
               results_checked, mismatch_count, results_pending);
      if (mismatch_count == 0 && results_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/wspid_pkg.sv
src/wspid_seq.sv
src/wspid_datapath.sv
src/wheel_speed_pid_motor_drive_core.sv
src/wspid_port_checker.sv
dv/wspid_speed_loop_checker.sv
dv/testbench.sv
